[design/ihop_pkg.sv]
// shared types and codes for the ip header offset parser
// no dependencies; imported by all modules but ihop_queue
`timescale 1ns / 1ps

package ihop_pkg;

    // network layer codes reported in net_kind
    localparam logic [1:0] NET_UNKNOWN = 2'd0;
    localparam logic [1:0] NET_IPV4    = 2'd1;
    localparam logic [1:0] NET_IPV6    = 2'd2;

    // one incoming packet byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // one per-packet parse result
    typedef struct packed {
        logic [1:0]  net_kind;
        logic        trans_found;
        logic [15:0] trans_offset;
        logic [7:0]  trans_proto;
        logic        payload_found;
        logic [15:0] payload_offset;
    } out_word_t;

endpackage

[design/ihop_front.sv]
// front end: accepts packet bytes and tags each with its byte position
// depends on ihop_pkg; feeds ihop_queue
`timescale 1ns / 1ps

module ihop_front
    import ihop_pkg::*;
#(
    parameter int OB = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  in_word_t                byte_word,
    output logic                    push_valid,
    input  logic                    push_ready,
    output logic [OB+$bits(in_word_t):0] push_data
);

    localparam logic [OB-1:0] POS_MAX = {OB{1'b1}};

    logic [OB-1:0] count_reg;
    logic [OB-1:0] count_next;
    logic          pos_ok;

    // word goes straight into the queue when it has room
    assign byte_ready = push_ready;
    assign push_valid = byte_valid;
    assign pos_ok     = (count_reg != POS_MAX);
    assign push_data  = {pos_ok, count_reg, byte_word};

    // saturating byte position, cleared after the last byte
    always_comb
    begin
        count_next = count_reg;
        if (byte_valid && push_ready)
        begin
            if (byte_word.last_byte)
                count_next = '0;
            else if (pos_ok)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

[design/ihop_queue.sv]
// two-entry word queue between the front end and the parse engine
// no package dependencies
`timescale 1ns / 1ps

module ihop_queue #(
    parameter int WIDTH = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic             full;
    logic             empty;

    // pointer flags with a wrap bit
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_reg[1] != rd_ptr_reg[1]) && (wr_ptr_reg[0] == rd_ptr_reg[0]);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_data   = mem[rd_ptr_reg[0]];

    // storage
    always_ff @(posedge clk)
    begin
        if (push_valid && !full)
            mem[wr_ptr_reg[0]] <= push_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push_valid && !full)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop_ready && !empty)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

endmodule

[design/ihop_back.sv]
// parse engine: walks the ip header chain one byte per cycle while no last byte
// waits on an unread result; holds the result word; needs ihop_pkg, pops ihop_queue
`timescale 1ns / 1ps

module ihop_back
    import ihop_pkg::*;
#(
    parameter int OB = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   net_offset,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  logic [OB+$bits(in_word_t):0] pop_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output out_word_t                    res_word
);

    localparam int IW = $bits(in_word_t);
    localparam int EW = OB + 12;
    localparam logic [EW-1:0] OFF_MAX = {{12{1'b0}}, {OB{1'b1}}};

    localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_ROUTING = 8'd43;
    localparam logic [7:0] PROTO_FRAG    = 8'd44;
    localparam logic [7:0] PROTO_AH      = 8'd51;
    localparam logic [7:0] PROTO_ICMPV6  = 8'd58;
    localparam logic [7:0] PROTO_DSTOPT  = 8'd60;

    typedef enum logic [7:0] {
        PH_NET    = 8'b0000_0001,
        PH_V4P    = 8'b0000_0010,
        PH_V6NH   = 8'b0000_0100,
        PH_EXTNH  = 8'b0000_1000,
        PH_EXTLEN = 8'b0001_0000,
        PH_TCPDO  = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_NONE   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_WAIT,
        REQ_ENTER,
        REQ_FOLLOW
    } req_t;

    // unpacked queue word
    logic          pos_ok;
    logic [OB-1:0] pos;
    in_word_t      cur;
    logic [EW-1:0] pos_e;
    logic          hit;
    logic          pop;

    // parse state
    phase_t        phase_reg,   phase_next;
    logic [OB-1:0] target_reg,  target_next;
    logic [7:0]    proto_reg,   proto_next;
    logic          is_ah_reg,   is_ah_next;
    logic [1:0]    kind_reg,    kind_next;
    logic [OB-1:0] trans_reg,   trans_next;
    logic [OB-1:0] payload_reg, payload_next;
    logic          broken_reg,  broken_next;

    // result holding register
    logic          res_valid_reg, res_valid_next;
    out_word_t     res_reg,       res_next;

    // step helpers
    req_t          req;
    logic [EW-1:0] req_pos;
    phase_t        wait_phase;
    logic [EW-1:0] pay_pos;
    logic          pay_set;
    logic [10:0]   ext_len;
    logic [OB:0]   len;
    logic          tr;
    logic          pl;

    assign pos_ok = pop_data[OB+IW];
    assign pos    = pop_data[OB+IW-1 -: OB];
    assign cur    = in_word_t'(pop_data[IW-1:0]);
    assign pos_e  = EW'(pos);
    assign hit    = pos_ok && (pos == target_reg);

    // a last byte waits only while an unread result sits in the output register
    assign pop       = pop_valid && (!cur.last_byte || !res_valid_reg || res_ready);
    assign pop_ready = pop;
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    assign ext_len = is_ah_reg ? {1'b0, cur.data_byte, 2'b00} : {cur.data_byte, 3'b000};

    // one parse step on the current byte
    always_comb
    begin
        phase_next   = phase_reg;
        target_next  = target_reg;
        proto_next   = proto_reg;
        is_ah_next   = is_ah_reg;
        kind_next    = kind_reg;
        trans_next   = trans_reg;
        payload_next = payload_reg;
        broken_next  = broken_reg;
        req          = REQ_NONE;
        req_pos      = '0;
        wait_phase   = PH_NONE;
        pay_pos      = '0;
        pay_set      = 1'b0;

        if (pos_ok)
        begin
            case (phase_reg)
                PH_NET:
                begin
                    if (pos == OB'(net_offset))
                    begin
                        if (cur.data_byte[7:4] == 4'd4)
                        begin
                            kind_next = NET_IPV4;
                            pay_pos   = pos_e + EW'({cur.data_byte[3:0], 2'b00});
                            if (pay_pos > OFF_MAX)
                                broken_next = 1'b1;
                            else
                                trans_next = OB'(pay_pos);
                            pay_pos    = '0;
                            req        = REQ_WAIT;
                            req_pos    = pos_e + EW'(9);
                            wait_phase = PH_V4P;
                        end
                        else if (cur.data_byte[7:4] == 4'd6)
                        begin
                            kind_next  = NET_IPV6;
                            req        = REQ_WAIT;
                            req_pos    = pos_e + EW'(6);
                            wait_phase = PH_V6NH;
                        end
                        else
                        begin
                            phase_next = PH_NONE;
                        end
                    end
                end
                PH_V4P:
                begin
                    if (hit)
                    begin
                        proto_next = cur.data_byte;
                        if (broken_next)
                            phase_next = PH_NONE;
                        else
                        begin
                            req     = REQ_ENTER;
                            req_pos = EW'(trans_reg);
                        end
                    end
                end
                PH_V6NH:
                begin
                    if (hit)
                    begin
                        proto_next = cur.data_byte;
                        req        = REQ_FOLLOW;
                        req_pos    = pos_e + EW'(34);
                    end
                end
                PH_EXTNH:
                begin
                    if (hit)
                    begin
                        is_ah_next = (proto_reg == PROTO_AH);
                        proto_next = cur.data_byte;
                        req        = REQ_WAIT;
                        req_pos    = pos_e + EW'(1);
                        wait_phase = PH_EXTLEN;
                    end
                end
                PH_EXTLEN:
                begin
                    if (hit)
                    begin
                        req     = REQ_FOLLOW;
                        req_pos = pos_e + EW'(7) + EW'(ext_len);
                    end
                end
                PH_TCPDO:
                begin
                    if (hit)
                    begin
                        pay_set    = 1'b1;
                        pay_pos    = EW'(trans_reg) + EW'({cur.data_byte[7:4], 2'b00});
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // extension header or transport
        if (req == REQ_FOLLOW)
        begin
            case (proto_next)
                PROTO_HOPOPT, PROTO_ROUTING, PROTO_FRAG, PROTO_AH, PROTO_DSTOPT:
                begin
                    req        = REQ_WAIT;
                    wait_phase = PH_EXTNH;
                end
                default:
                    req = REQ_ENTER;
            endcase
        end

        // move to the next byte of interest
        if (req == REQ_WAIT)
        begin
            if (req_pos >= OFF_MAX)
            begin
                broken_next = 1'b1;
                phase_next  = PH_NONE;
            end
            else
            begin
                target_next = OB'(req_pos);
                phase_next  = wait_phase;
            end
        end

        // transport header reached
        if (req == REQ_ENTER)
        begin
            if (req_pos > OFF_MAX)
            begin
                broken_next = 1'b1;
                phase_next  = PH_NONE;
            end
            else
            begin
                trans_next   = OB'(req_pos);
                payload_next = '0;
                phase_next   = PH_DONE;
                case (proto_next)
                    PROTO_ICMP, PROTO_ICMPV6:
                    begin
                        pay_set = 1'b1;
                        pay_pos = req_pos + EW'(4);
                    end
                    PROTO_UDP:
                    begin
                        pay_set = 1'b1;
                        pay_pos = req_pos + EW'(8);
                    end
                    PROTO_TCP:
                    begin
                        payload_next = OB'(req_pos);
                        if (req_pos + EW'(12) < OFF_MAX)
                        begin
                            target_next = OB'(req_pos + EW'(12));
                            phase_next  = PH_TCPDO;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // payload offset with range check
        if (pay_set)
        begin
            if (pay_pos > OFF_MAX)
                broken_next = 1'b1;
            else
                payload_next = OB'(pay_pos);
        end
    end

    // result word for a packet that ends on this byte
    always_comb
    begin
        len = {1'b0, pos} + 1'b1;
        tr  = ((phase_next == PH_TCPDO) || (phase_next == PH_DONE))
              && ({1'b0, trans_next} < len);
        pl  = 1'b0;
        case (proto_next)
            PROTO_ICMP, PROTO_ICMPV6, PROTO_UDP, PROTO_TCP:
                pl = tr && !broken_next && ({1'b0, payload_next} < len);
            default:
                pl = 1'b0;
        endcase
        res_next.net_kind       = kind_next;
        res_next.trans_found    = tr;
        res_next.trans_offset   = tr ? 16'(trans_next) : 16'd0;
        res_next.trans_proto    = tr ? proto_next : 8'd0;
        res_next.payload_found  = pl;
        res_next.payload_offset = pl ? 16'(payload_next) : 16'd0;
    end

    // output handshake
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && cur.last_byte)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && cur.last_byte)
            res_reg <= res_next;
    end

    // state update, cleared after each packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NET;
            target_reg    <= '0;
            proto_reg     <= '0;
            is_ah_reg     <= 1'b0;
            kind_reg      <= NET_UNKNOWN;
            trans_reg     <= '0;
            payload_reg   <= '0;
            broken_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                if (cur.last_byte)
                begin
                    phase_reg   <= PH_NET;
                    target_reg  <= '0;
                    proto_reg   <= '0;
                    is_ah_reg   <= 1'b0;
                    kind_reg    <= NET_UNKNOWN;
                    trans_reg   <= '0;
                    payload_reg <= '0;
                    broken_reg  <= 1'b0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    target_reg  <= target_next;
                    proto_reg   <= proto_next;
                    is_ah_reg   <= is_ah_next;
                    kind_reg    <= kind_next;
                    trans_reg   <= trans_next;
                    payload_reg <= payload_next;
                    broken_reg  <= broken_next;
                end
            end
        end
    end

endmodule

[design/ip_header_offset_parser.sv]
// Result: the last byte of a packet is registered in the queue, then the parse engine
// registers its result word, held back while the previous result still waits there.
// Throughput: one byte per cycle unless a last byte waits on the output; the engine
// handles one byte a cycle and the two-entry queue holds two bytes while a result waits.
// Reset: asynchronous active low; clears the parse state, the queue, net_offset and
// the output valid flag; no clearing pass, bytes are taken once reset is released.
`timescale 1ns / 1ps

module ip_header_offset_parser
    import ihop_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  in_word_t   byte_word,
    output logic       res_valid,
    input  logic       res_ready,
    output out_word_t  res_word,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int QW = OFFSET_BITS + $bits(in_word_t) + 1;

    logic [7:0]    net_offset_reg;
    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;

    // network header offset register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            net_offset_reg <= 8'd0;
        else if (cfg_valid)
            net_offset_reg <= cfg_data;
    end

    // byte tagging
    ihop_front #(
        .OB (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    ihop_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // header walk and result
    ihop_back #(
        .OB (OFFSET_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .net_offset (net_offset_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word)
    );

endmodule

[test/tb.sv]
// testbench for ip_header_offset_parser: random and directed packets, byte-level
// prediction of the per-packet offset result; depends on ihop_pkg and the design top
`timescale 1ns / 1ps

module tb;
    import ihop_pkg::*;

    // protocol and header codes seen on the wire
    localparam logic [3:0] IP_V4       = 4'd4;
    localparam logic [3:0] IP_V6       = 4'd6;
    localparam logic [7:0] PROTO_ICMP  = 8'd1;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;
    localparam logic [7:0] EXT_HOP     = 8'd0;
    localparam logic [7:0] EXT_ROUTE   = 8'd43;
    localparam logic [7:0] EXT_FRAG    = 8'd44;
    localparam logic [7:0] EXT_AH      = 8'd51;
    localparam logic [7:0] EXT_DEST    = 8'd60;
    localparam logic [7:0] EXT_KINDS [5] = '{EXT_HOP, EXT_ROUTE, EXT_FRAG, EXT_AH, EXT_DEST};

    localparam int unsigned POS_MAX = 65535;
    localparam int unsigned SETTLE  = 8;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 5000;

    typedef enum logic [2:0] {
        ST_NET, ST_V4PROTO, ST_V6NH, ST_EXTNH, ST_EXTLEN, ST_TCPDO, ST_DONE, ST_NONE
    } parse_st_t;

    typedef logic [7:0] hdr_list_t[$];

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    in_word_t   byte_word  = '0;
    logic       res_valid;
    logic       res_ready  = 1'b0;
    out_word_t  res_word;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data   = '0;

    // stimulus and checking state
    in_word_t    byte_q[$];
    out_word_t   expected_res[$];
    logic [7:0]  pkt_buf[$];
    logic        byte_acc   = 1'b0;
    logic        no_idle    = 1'b0;
    logic        hold_kick  = 1'b0;
    logic        hold_seen  = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned err_cnt    = 0;
    int unsigned n_cfg      = 0;
    int unsigned n_bytes    = 0;
    int unsigned n_pkts     = 0;
    int unsigned n_trans    = 0;
    int unsigned n_pay      = 0;
    int unsigned idle_cycles = 0;

    // parser shadow state
    logic [7:0]  net_off   = '0;
    int unsigned pos_cnt   = 0;
    parse_st_t   phase     = ST_NET;
    int unsigned tgt       = 0;
    logic [7:0]  cur_proto = '0;
    logic        ah_hdr    = 1'b0;
    logic [1:0]  kind      = NET_UNKNOWN;
    int unsigned t_start   = 0;
    int unsigned p_start   = 0;
    logic        broken    = 1'b0;

    ip_header_offset_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // wait for a byte position, or give up when it is out of range
    function automatic void park_at(int unsigned p, parse_st_t st);
        if (p >= POS_MAX)
        begin
            broken = 1'b1;
            phase  = ST_NONE;
        end
        else
        begin
            tgt   = p;
            phase = st;
        end
    endfunction

    function automatic void note_payload(int unsigned p);
        if (p > POS_MAX)
            broken = 1'b1;
        else
            p_start = p;
    endfunction

    // transport header reached at offset t
    function automatic void start_transport(int unsigned t);
        if (t > POS_MAX)
        begin
            broken = 1'b1;
            phase  = ST_NONE;
        end
        else
        begin
            t_start = t;
            p_start = 0;
            phase   = ST_DONE;
            case (cur_proto)
                PROTO_ICMP, PROTO_ICMP6: note_payload(t + 4);
                PROTO_UDP:               note_payload(t + 8);
                PROTO_TCP:
                begin
                    p_start = t;
                    if (t + 12 < POS_MAX)
                    begin
                        tgt   = t + 12;
                        phase = ST_TCPDO;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // another extension header or the transport header
    function automatic void chain_next(int unsigned t);
        if (cur_proto inside {EXT_HOP, EXT_ROUTE, EXT_FRAG, EXT_AH, EXT_DEST})
            park_at(t, ST_EXTNH);
        else
            start_transport(t);
    endfunction

    // advance the shadow parser by one accepted byte
    function automatic void parse_byte(in_word_t w);
        int unsigned pos;
        int unsigned b;
        int unsigned len;
        logic        tr;
        logic        pl;
        out_word_t   r;
        pos = pos_cnt;
        b   = w.data_byte;
        if (pos < POS_MAX)
        begin
            case (phase)
                ST_NET:
                    if (pos == net_off)
                    begin
                        if (w.data_byte[7:4] == IP_V4)
                        begin
                            kind = NET_IPV4;
                            if (pos + (b & 15) * 4 > POS_MAX)
                                broken = 1'b1;
                            else
                                t_start = pos + (b & 15) * 4;
                            park_at(pos + 9, ST_V4PROTO);
                        end
                        else if (w.data_byte[7:4] == IP_V6)
                        begin
                            kind = NET_IPV6;
                            park_at(pos + 6, ST_V6NH);
                        end
                        else
                            phase = ST_NONE;
                    end
                ST_V4PROTO:
                    if (pos == tgt)
                    begin
                        cur_proto = w.data_byte;
                        if (broken)
                            phase = ST_NONE;
                        else
                            start_transport(t_start);
                    end
                ST_V6NH:
                    if (pos == tgt)
                    begin
                        cur_proto = w.data_byte;
                        chain_next(pos + 34);
                    end
                ST_EXTNH:
                    if (pos == tgt)
                    begin
                        ah_hdr    = (cur_proto == EXT_AH);
                        cur_proto = w.data_byte;
                        park_at(pos + 1, ST_EXTLEN);
                    end
                ST_EXTLEN:
                    if (pos == tgt)
                        chain_next(pos + 7 + b * (ah_hdr ? 4 : 8));
                ST_TCPDO:
                    if (pos == tgt)
                    begin
                        note_payload(t_start + ((b & 8'hF0) >> 2));
                        phase = ST_DONE;
                    end
                default: ;
            endcase
        end
        pos_cnt = (pos < POS_MAX) ? pos + 1 : pos;

        // end of packet: form the result and clear for the next one
        if (w.last_byte)
        begin
            len = pos + 1;
            tr  = (phase == ST_TCPDO || phase == ST_DONE) && t_start < len;
            pl  = tr && !broken && p_start < len
                  && (cur_proto inside {PROTO_ICMP, PROTO_ICMP6, PROTO_UDP, PROTO_TCP});
            r.net_kind       = kind;
            r.trans_found    = tr;
            r.trans_offset   = tr ? t_start[15:0] : 16'd0;
            r.trans_proto    = tr ? cur_proto : 8'd0;
            r.payload_found  = pl;
            r.payload_offset = pl ? p_start[15:0] : 16'd0;
            expected_res.push_back(r);
            n_trans += tr;
            n_pay   += pl;
            pos_cnt   = 0;
            phase     = ST_NET;
            tgt       = 0;
            cur_proto = '0;
            ah_hdr    = 1'b0;
            kind      = NET_UNKNOWN;
            t_start   = 0;
            p_start   = 0;
            broken    = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // sample all handshakes at the rising edge
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        byte_acc <= rst_n && byte_valid && byte_ready;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    want = expected_res.pop_front();
                    check_field("net_kind", want.net_kind, res_word.net_kind);
                    check_field("trans_found", want.trans_found, res_word.trans_found);
                    check_field("trans_offset", want.trans_offset, res_word.trans_offset);
                    check_field("trans_proto", want.trans_proto, res_word.trans_proto);
                    check_field("payload_found", want.payload_found, res_word.payload_found);
                    check_field("payload_offset", want.payload_offset,
                                res_word.payload_offset);
                end
            end
            if (byte_valid && byte_ready)
                parse_byte(byte_word);
            if (cfg_valid && cfg_ready)
            begin
                net_off = cfg_data;
                n_cfg++;
            end
        end
    end

    // byte driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (!byte_valid || byte_acc)
        begin
            if (byte_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28))
            begin
                byte_word  <= byte_q.pop_front();
                byte_valid <= 1'b1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= no_idle || ($urandom_range(0, 99) >= 28);
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("ip_header_offset_parser test failed");
            $finish;
        end
    end

    function automatic void put_byte(int unsigned p, logic [7:0] v);
        while (pkt_buf.size() <= p)
            pkt_buf.push_back(8'($urandom_range(0, 255)));
        pkt_buf[p] = v;
    endfunction

    // queue the first len bytes of the packet buffer, padding with random bytes
    task automatic send_pkt(int unsigned len);
        in_word_t w;
        while (pkt_buf.size() < len)
            pkt_buf.push_back(8'($urandom_range(0, 255)));
        for (int unsigned i = 0; i < len; i++)
        begin
            w.data_byte = pkt_buf[i];
            w.last_byte = (i == len - 1);
            byte_q.push_back(w);
        end
        n_bytes += len;
        n_pkts++;
    endtask

    // build an ip packet: chain holds the next-header values in order, lens the
    // extension lengths; rel moves the end relative to the natural header end
    task automatic emit_packet(int unsigned off, logic [7:0] vb, hdr_list_t chain,
                               hdr_list_t lens, logic [3:0] tcp_do, int rel);
        int unsigned p;
        int unsigned t_at;
        int unsigned nat;
        int          len;
        pkt_buf.delete();
        put_byte(off, vb);
        t_at = off + 1;
        if (vb[7:4] == IP_V4 && chain.size() != 0)
        begin
            put_byte(off + 9, chain[0]);
            t_at = off + vb[3:0] * 4;
        end
        else if (vb[7:4] == IP_V6 && chain.size() != 0)
        begin
            put_byte(off + 6, chain[0]);
            p = off + 40;
            for (int i = 1; i < chain.size(); i++)
            begin
                put_byte(p, chain[i]);
                put_byte(p + 1, lens[i-1]);
                p += (chain[i-1] == EXT_AH) ? lens[i-1] * 4 + 8 : (lens[i-1] + 1) * 8;
            end
            t_at = p;
        end
        if (chain.size() != 0 && chain[chain.size()-1] == PROTO_TCP)
            put_byte(t_at + 12, {tcp_do, 4'($urandom_range(0, 15))});
        nat = (pkt_buf.size() > t_at) ? pkt_buf.size() : t_at;
        len = int'(nat) + rel;
        send_pkt((len < 1) ? 1 : len);
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 4))
            0:       return PROTO_ICMP;
            1:       return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_ICMP6;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // hold until every word is through, then let the pipeline settle
    task automatic wait_idle();
        while (!(byte_q.size() == 0 && !byte_valid && expected_res.size() == 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write, offered from a falling edge and taken at the next rising edge
    task automatic write_offset(logic [7:0] v);
        wait_idle();
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        hdr_list_t   chain;
        hdr_list_t   lens;
        int unsigned off;
        int unsigned pick;
        int unsigned ph_bytes;
        int unsigned ph_pkts;
        int unsigned n_ext;
        int unsigned nat;
        int          rel;
        logic [7:0]  vb;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed packets at the reset offset of zero
        lens.delete();
        chain = '{PROTO_TCP};
        emit_packet(0, 8'h45, chain, lens, 4'd5, 2);
        chain = '{PROTO_UDP};
        emit_packet(0, 8'h45, chain, lens, 4'd0, 8);
        chain = '{PROTO_ICMP};
        emit_packet(0, 8'h45, chain, lens, 4'd0, 4);
        chain = '{8'd99};
        emit_packet(0, 8'h46, chain, lens, 4'd0, 3);
        // tcp data-offset byte missing at the end
        chain = '{PROTO_TCP};
        emit_packet(0, 8'h45, chain, lens, 4'd7, -1);
        // packet ends before the protocol byte
        emit_packet(0, 8'h45, chain, lens, 4'd5, -28);
        emit_packet(0, 8'h4F, chain, lens, 4'd15, 0);
        chain = '{PROTO_UDP};
        emit_packet(0, 8'h40, chain, lens, 4'd0, 20);
        chain = '{PROTO_ICMP6};
        emit_packet(0, 8'h60, chain, lens, 4'd0, 6);
        // every extension header kind in one chain
        chain = '{EXT_HOP, EXT_ROUTE, EXT_FRAG, EXT_DEST, EXT_AH, PROTO_TCP};
        lens  = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
        emit_packet(0, 8'h6F, chain, lens, 4'd8, 4);
        // packet ends inside the extension chain
        chain = '{EXT_HOP, EXT_FRAG, PROTO_UDP};
        lens  = '{8'd3, 8'd0};
        emit_packet(0, 8'h60, chain, lens, 4'd0, -30);
        chain = '{EXT_AH, PROTO_TCP};
        lens  = '{8'd2};
        emit_packet(0, 8'h60, chain, lens, 4'd15, 4);
        // unknown versions and a one-byte packet
        chain.delete();
        lens.delete();
        emit_packet(0, 8'hF0, chain, lens, 4'd0, 10);
        emit_packet(0, 8'h00, chain, lens, 4'd0, 0);

        // network header at the last possible offset, then a packet that ends before it
        write_offset(8'd255);
        chain = '{PROTO_UDP};
        emit_packet(255, 8'h45, chain, lens, 4'd0, 2);
        pkt_buf.delete();
        send_pkt(20);

        // random phases over several offsets
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       off = 14;
                1:       off = $urandom_range(1, 40);
                default: off = $urandom_range(1, 20);
            endcase
            write_offset(off[7:0]);
            if (ph == 0)
                hold_kick = ~hold_kick;
            no_idle  = (ph == 1);
            ph_bytes = 0;
            ph_pkts  = 0;
            while (ph_bytes < 60 || ph_pkts < 3)
            begin
                nat  = n_bytes;
                pick = $urandom_range(0, 99);
                chain.delete();
                lens.delete();
                if (pick < 90)
                begin
                    if (pick < 40)
                    begin
                        vb = {IP_V4, ($urandom_range(0, 3) == 0)
                                     ? 4'($urandom_range(0, 15)) : 4'd5};
                        chain.push_back(pick_proto());
                    end
                    else if (pick < 80)
                    begin
                        vb    = {IP_V6, 4'($urandom_range(0, 15))};
                        n_ext = $urandom_range(0, 3);
                        for (int i = 0; i < n_ext; i++)
                        begin
                            chain.push_back(EXT_KINDS[$urandom_range(0, 4)]);
                            lens.push_back(($urandom_range(0, 7) == 0)
                                           ? 8'($urandom_range(0, 31))
                                           : 8'($urandom_range(0, 3)));
                        end
                        chain.push_back(pick_proto());
                    end
                    else
                    begin
                        vb = 8'($urandom_range(0, 255));
                        if (vb[7:4] == IP_V4 || vb[7:4] == IP_V6)
                            vb[7] = 1'b1;
                    end
                    // mostly complete packets, some cut short
                    if ($urandom_range(0, 99) < 15)
                        rel = -int'($urandom_range(1, 20));
                    else
                        rel = $urandom_range(0, 8);
                    emit_packet(off, vb, chain, lens, 4'($urandom_range(0, 15)), rel);
                end
                else
                begin
                    pkt_buf.delete();
                    send_pkt($urandom_range(1, off + 12));
                end
                ph_bytes += n_bytes - nat;
                ph_pkts++;
            end
            wait_idle();
            no_idle = 1'b0;
        end

        wait_idle();
        $display("covered %0d packets in %0d bytes across %0d offset writes",
                 n_pkts, n_bytes, n_cfg);
        $display("transport found in %0d results, payload found in %0d", n_trans, n_pay);
        if (err_cnt == 0 && expected_res.size() == 0)
            $display("ip_header_offset_parser test passed");
        else
            $display("ip_header_offset_parser test failed");
        $finish;
    end

endmodule

[filelist.f]
design/ihop_pkg.sv
design/ihop_front.sv
design/ihop_queue.sv
design/ihop_back.sv
design/ip_header_offset_parser.sv
test/tb.sv
